/* design/sha1sh_pkg.sv */
package sha1sh_pkg;

  // initial chaining value
  localparam logic [31:0] H0 = 32'h6745_2301;
  localparam logic [31:0] H1 = 32'hEFCD_AB89;
  localparam logic [31:0] H2 = 32'h98BA_DCFE;
  localparam logic [31:0] H3 = 32'h1032_5476;
  localparam logic [31:0] H4 = 32'hC3D2_E1F0;

  // round constants, one per group of twenty rounds
  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  // padding marker byte in the leading position of a word
  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned BLOCK_WORDS  = 16;
  localparam int unsigned ROUNDS       = 80;
  localparam int unsigned BYTES_MAX    = 4;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (WORD_BITS - s));
  endfunction

endpackage

/* design/sha1_stream_hasher_core.sv */
// a word that does not close a block is stored and the core stays ready; the word that
// fills a block starts the rounds of the single round unit and then a fold of the result;
// no new word is taken until the core is idle again; a last beat adds padding and length
// writes, one or two compressions and a final step that moves out the digest
// reset: synchronous active-high rst loads the initial chaining value, clears the
// length and fill count and drops out_valid; the block buffer is not cleared
module sha1_stream_hasher_core import sha1sh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word0,
  output logic [31:0] digest_word1,
  output logic [31:0] digest_word2,
  output logic [31:0] digest_word3,
  output logic [31:0] digest_word4
);

  // sequencer states
  //   S_IDLE  take message words
  //   S_PAD   write marker and zero words, one per cycle, then the high length word
  //   S_LEN   write the low length word, start the final compression
  //   S_ROUND one round per cycle through the shared round unit
  //   S_FOLD  add working variables into the chaining value
  //   S_EMIT  move the digest into the output register
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  localparam int unsigned IDX_W = $clog2(BLOCK_WORDS);
  localparam int unsigned RND_W = $clog2(ROUNDS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_WORDS - 1);
  localparam logic [IDX_W-1:0] IDX_LEN  = IDX_W'(BLOCK_WORDS - 2);
  localparam logic [RND_W-1:0] RND_END  = RND_W'(ROUNDS - 1);

  state_t            state;
  state_t            ret_state;   // where to go after a compression
  state_t            next_after;  // follow-up state for the current write
  logic [IDX_W-1:0]  widx;        // word fill count of the block buffer
  logic [RND_W-1:0]  rnd;
  logic              marker;      // 0x80 byte already placed
  logic [63:0]       bit_length;
  logic [31:0]       chain [5];
  // block buffer doubles as the message schedule window: during the rounds
  // slot 0 holds w[r] and new schedule words shift in at the top
  logic [31:0]       wbuf [BLOCK_WORDS];
  logic [31:0]       a, b, c, d, e;

  logic              in_fire;
  logic [2:0]        cnt_eff;
  logic [31:0]       last_word;
  logic [31:0]       in_word;
  logic [63:0]       len_sum;
  logic [31:0]       rf, rk, rt, wnew;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // counts above four, and any count on a word that is not last, take all four bytes
  assign cnt_eff = (!last || byte_count > 3'(BYTES_MAX)) ? 3'(BYTES_MAX) : byte_count;

  // final word: keep the valid leading bytes and drop the marker right behind them;
  // an empty final beat is the marker word alone
  always_comb begin
    case (cnt_eff)
      3'd0:    last_word = PAD_WORD;
      3'd1:    last_word = {data_word[31:24], 24'h80_0000};
      3'd2:    last_word = {data_word[31:16], 16'h8000};
      3'd3:    last_word = {data_word[31:8], 8'h80};
      default: last_word = data_word;
    endcase
  end

  assign in_word    = last ? last_word : data_word;
  assign len_sum    = bit_length + {58'd0, cnt_eff, 3'd0};
  assign next_after = last ? S_PAD : S_IDLE;

  // shared round unit: choice, parity or majority by round group
  always_comb begin
    if (rnd < RND_W'(20)) begin
      rf = (b & c) | (~b & d);
      rk = K0;
    end else if (rnd < RND_W'(40)) begin
      rf = b ^ c ^ d;
      rk = K1;
    end else if (rnd < RND_W'(60)) begin
      rf = (b & c) | (b & d) | (c & d);
      rk = K2;
    end else begin
      rf = b ^ c ^ d;
      rk = K3;
    end
    rt   = rotl(a, 5) + rf + e + rk + wbuf[0];
    wnew = rotl(wbuf[13] ^ wbuf[8] ^ wbuf[2] ^ wbuf[0], 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret_state  <= S_IDLE;
      widx       <= '0;
      rnd        <= '0;
      marker     <= 1'b0;
      bit_length <= '0;
      chain[0]   <= H0;
      chain[1]   <= H1;
      chain[2]   <= H2;
      chain[3]   <= H3;
      chain[4]   <= H4;
      out_valid  <= 1'b0;
    end else begin
      // in S_EMIT a taken digest is replaced by the next one below
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            wbuf[widx] <= in_word;
            widx       <= widx + 1'b1;
            bit_length <= len_sum;
            marker     <= (cnt_eff != 3'(BYTES_MAX));
            // the sixteenth word starts a compression
            if (widx == IDX_LAST) begin
              state     <= S_ROUND;
              ret_state <= next_after;
              rnd       <= '0;
              a <= chain[0];
              b <= chain[1];
              c <= chain[2];
              d <= chain[3];
              e <= chain[4];
            end else begin
              state <= next_after;
            end
          end
        end
        S_PAD: begin
          if (marker && widx == IDX_LEN) begin
            // length goes in the last two words, high word first
            wbuf[IDX_LEN] <= bit_length[63:32];
            widx          <= IDX_LAST;
            state         <= S_LEN;
          end else begin
            wbuf[widx] <= marker ? 32'd0 : PAD_WORD;
            marker     <= 1'b1;
            widx       <= widx + 1'b1;
            // marker landing in the length words spills into a second block
            if (widx == IDX_LAST) begin
              state     <= S_ROUND;
              ret_state <= S_PAD;
              rnd       <= '0;
              a <= chain[0];
              b <= chain[1];
              c <= chain[2];
              d <= chain[3];
              e <= chain[4];
            end
          end
        end
        S_LEN: begin
          wbuf[IDX_LAST] <= bit_length[31:0];
          widx           <= '0;
          state          <= S_ROUND;
          ret_state      <= S_EMIT;
          rnd            <= '0;
          a <= chain[0];
          b <= chain[1];
          c <= chain[2];
          d <= chain[3];
          e <= chain[4];
        end
        S_ROUND: begin
          for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            wbuf[i] <= wbuf[i+1];
          end
          wbuf[IDX_LAST] <= wnew;
          a   <= rt;
          b   <= a;
          c   <= rotl(b, 30);
          d   <= c;
          e   <= d;
          rnd <= rnd + 1'b1;
          if (rnd == RND_END) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          state    <= ret_state;
        end
        S_EMIT: begin
          // wait for the output register to free up, then reinitialize
          if (!out_valid || out_ready) begin
            digest_word0 <= chain[0];
            digest_word1 <= chain[1];
            digest_word2 <= chain[2];
            digest_word3 <= chain[3];
            digest_word4 <= chain[4];
            out_valid    <= 1'b1;
            chain[0]     <= H0;
            chain[1]     <= H1;
            chain[2]     <= H2;
            chain[3]     <= H3;
            chain[4]     <= H4;
            bit_length   <= '0;
            marker       <= 1'b0;
            widx         <= '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/sha1sh_checker.sv */
module sha1sh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word0,
  input logic [31:0] digest_word1,
  input logic [31:0] digest_word2,
  input logic [31:0] digest_word3,
  input logic [31:0] digest_word4
);

  // held digest beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(digest_word0) &&
      $stable(digest_word1) && $stable(digest_word2) && $stable(digest_word3) &&
      $stable(digest_word4)))
    else $error("digest beat changed while stalled");

  // a last beat always starts padding or a compression, so input closes next cycle
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last) |=> !in_ready)
    else $error("input open right after a last beat");

  // a new digest only appears after a busy stretch
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("digest appeared while idle");

  // reset leaves the block idle with no digest pending
  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("bad state after reset");

endmodule

bind sha1_stream_hasher_core sha1sh_checker u_sha1sh_checker (.*);

/* tb/sv/sha1_stream_hasher_core_tb.sv */
`timescale 1ns / 100ps

module sha1_stream_hasher_core_tb;

  // sha-1 initial chaining value and round constants, kept separate from the design's
  localparam logic [31:0] IV0 = 32'h6745_2301;
  localparam logic [31:0] IV1 = 32'hEFCD_AB89;
  localparam logic [31:0] IV2 = 32'h98BA_DCFE;
  localparam logic [31:0] IV3 = 32'h1032_5476;
  localparam logic [31:0] IV4 = 32'hC3D2_E1F0;
  localparam logic [31:0] RK0 = 32'h5A82_7999;
  localparam logic [31:0] RK1 = 32'h6ED9_EBA1;
  localparam logic [31:0] RK2 = 32'h8F1B_BCDC;
  localparam logic [31:0] RK3 = 32'hCA62_C1D6;

  localparam int RANDOM_BEATS = 1300;
  localparam int HOLD_CYCLES  = 800;
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int PRINT_CAP    = 60;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last_flag;
  } word_beat_t;

  // [0] is digest_word0
  typedef logic [4:0][31:0] digest_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  sha1_stream_hasher_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digest_word0 (digest_word0),
    .digest_word1 (digest_word1),
    .digest_word2 (digest_word2),
    .digest_word3 (digest_word3),
    .digest_word4 (digest_word4)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  word_beat_t beats_to_send[$];
  digest_t    digests_due[$];

  int total_beats   = 0;
  int beats_taken   = 0;
  int digests_seen  = 0;
  int message_count = 0;
  int longest_msg   = 0;
  int errors        = 0;
  int cycles        = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  // ---------------------------------------------------------------------------
  // hash predictor: chaining words, 16-word block, byte fill and message length
  // ---------------------------------------------------------------------------
  logic [31:0] chain_h[5];
  logic [31:0] blk_words[16];
  logic [5:0]  blk_fill;
  logic [63:0] msg_bits;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void sha_restart();
    chain_h[0] = IV0;
    chain_h[1] = IV1;
    chain_h[2] = IV2;
    chain_h[3] = IV3;
    chain_h[4] = IV4;
    blk_fill = '0;
    msg_bits = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) w[r] = blk_words[r];
    for (int r = 16; r < 80; r++) w[r] = rol32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RK0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RK1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RK2;
      end else begin
        f = b ^ c ^ d;
        k = RK3;
      end
      t = rol32(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // a word is cleared on its first byte, so stale buffer contents never leak in
  function automatic void sha_put_byte(input logic [7:0] bval);
    if (blk_fill[1:0] == 2'd0) blk_words[blk_fill[5:2]] = '0;
    blk_words[blk_fill[5:2]][8 * (3 - blk_fill[1:0]) +: 8] = bval;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) sha_compress();
  endfunction

  // returns 1 and the digest when the beat closes a message
  function automatic bit sha_absorb(input word_beat_t bt, output digest_t dg);
    int          n;
    logic [63:0] len_snap;
    dg = '0;
    n = bt.count;
    // counts above four, and any short count on a non-final beat, take the whole word
    if (n > 4 || !bt.last_flag) n = 4;
    for (int i = 0; i < n; i++) sha_put_byte(bt.data[31 - 8*i -: 8]);
    msg_bits = msg_bits + 64'(n * 8);
    if (!bt.last_flag) return 1'b0;
    // pad: marker byte, zeros up to byte 56, then the 64-bit length
    len_snap = msg_bits;
    sha_put_byte(8'h80);
    while (blk_fill != 6'd56) sha_put_byte(8'h00);
    for (int i = 0; i < 8; i++) sha_put_byte(len_snap[63 - 8*i -: 8]);
    for (int i = 0; i < 5; i++) dg[i] = chain_h[i];
    sha_restart();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_beat(input logic [31:0] d, input logic [2:0] n, input logic l);
    word_beat_t bt;
    bt.data = d;
    bt.count = n;
    bt.last_flag = l;
    beats_to_send.push_back(bt);
  endfunction

  // random content; mostly full words, now and then an odd count mid-message
  function automatic void queue_message(input int words);
    logic [2:0] n;
    for (int i = 0; i < words - 1; i++) begin
      n = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      queue_beat($urandom, n, 1'b0);
    end
    queue_beat($urandom, 3'($urandom_range(0, 7)), 1'b1);
    message_count++;
    if (words > longest_msg) longest_msg = words;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (errors < PRINT_CAP)
      $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // idle odds per phase: sender 36 / receiver 87, then swapped, then none
  function automatic int sender_idle_pct();
    if (beats_taken < total_beats / 3) return 36;
    if (beats_taken < 2 * total_beats / 3) return 87;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (beats_taken < total_beats / 3) return 87;
    if (beats_taken < 2 * total_beats / 3) return 36;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: holds a beat until accepted, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_beats
    word_beat_t nxt;
    word_beat_t taken;
    digest_t    dg;
    bit         holding;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        taken.data = data_word;
        taken.count = byte_count;
        taken.last_flag = last;
        if (sha_absorb(taken, dg)) digests_due.push_back(dg);
        beats_taken++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (beats_to_send.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          nxt = beats_to_send.pop_front();
          in_valid   <= 1'b1;
          data_word  <= nxt.data;
          byte_count <= nxt.count;
          last       <= nxt.last_flag;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off late in the no-idle phase; the sender keeps
  // offering so the core backs up and drops in_ready
  always @(posedge clk) begin : long_hold
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_taken >= 3 * total_beats / 4) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : drive_ready
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every accepted digest against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_digests
    digest_t want;
    if (!rst && out_valid && out_ready) begin
      if (digests_due.size() == 0) begin
        flag_mismatch("digest with none pending, word0", digest_word0, '0);
      end else begin
        want = digests_due.pop_front();
        if (digest_word0 !== want[0]) flag_mismatch("digest_word0", digest_word0, want[0]);
        if (digest_word1 !== want[1]) flag_mismatch("digest_word1", digest_word1, want[1]);
        if (digest_word2 !== want[2]) flag_mismatch("digest_word2", digest_word2, want[2]);
        if (digest_word3 !== want[3]) flag_mismatch("digest_word3", digest_word3, want[3]);
        if (digest_word4 !== want[4]) flag_mismatch("digest_word4", digest_word4, want[4]);
        digests_seen++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digests outstanding", cycles,
               digests_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int words;
    int pick;
    sha_restart();

    // empty message
    queue_beat(32'h0000_0000, 3'd0, 1'b1);
    // "abc" in one short final word
    queue_beat(32'h6162_6300, 3'd3, 1'b1);
    // counts above four on a final beat act as four
    queue_beat(32'hFFFF_FFFF, 3'd5, 1'b1);
    queue_beat(32'h0000_0000, 3'd7, 1'b1);
    // short counts mid-message take the whole word
    queue_beat(32'h0000_0000, 3'd0, 1'b0);
    queue_beat(32'hFFFF_FFFF, 3'd6, 1'b1);
    queue_beat(32'hA5A5_5A5A, 3'd1, 1'b0);
    queue_beat(32'h1234_5678, 3'd2, 1'b0);
    queue_beat(32'h8000_0001, 3'd1, 1'b1);
    queue_beat(32'hFEDC_BA98, 3'd2, 1'b1);
    queue_beat(32'h0123_4567, 3'd4, 1'b1);
    // 56 bytes: the length no longer fits, padding spills into a second block
    for (int i = 0; i < 13; i++) queue_beat($urandom, 3'd4, 1'b0);
    queue_beat($urandom, 3'd4, 1'b1);
    message_count += 9;
    longest_msg = 14;

    // random messages, weighted toward lengths around the padding boundary
    while (beats_to_send.size() < RANDOM_BEATS + 25) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) words = $urandom_range(1, 12);
      else if (pick < 9) words = $urandom_range(13, 17);
      else words = $urandom_range(18, 64);
      queue_message(words);
    end
    total_beats = beats_to_send.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (beats_to_send.size() != 0 || in_valid || digests_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d beats in %0d messages (longest %0d words), %0d digests checked",
             beats_taken, message_count, longest_msg, digests_seen);
    $display("idle mixes sender/receiver 36/87, 87/36, 0/0, plus one %0d-cycle output hold",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
design/sha1sh_pkg.sv
design/sha1_stream_hasher_core.sv
design/sha1sh_checker.sv
tb/sv/sha1_stream_hasher_core_tb.sv
